// ===== design/gb5_pkg.sv =====
// Shared types and constants of the 5x5 binomial blur.
package gb5_pkg;

  localparam int PIX_W     = 16;
  localparam int POS_W     = 13;
  localparam int CFG_W     = 14;
  localparam int IDX_W     = 8;
  localparam int MAX_WIDTH = 8192;
  localparam int LINES     = 4;
  localparam int TAPS      = 5;
  localparam int VSUM_W    = PIX_W + 4;
  localparam int HSUM_W    = VSUM_W + 4;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);

  localparam logic [CFG_W-1:0] DIM_MIN      = CFG_W'(5);
  localparam logic [CFG_W-1:0] WIDTH_MAX    = CFG_W'(MAX_WIDTH);
  localparam logic [CFG_W-1:0] HEIGHT_MAX   = CFG_W'(8192);
  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(7680);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(4320);

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = IDX_W'(1);

  // One vertical column of the window, top row in entry 0.
  typedef logic [TAPS-1:0][PIX_W-1:0] col_t;

  // Position information of one accepted item.
  typedef struct packed {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] ctr_col;
    logic [POS_W-1:0] ctr_row;
    logic             emit;
    logic             last;
  } pos_t;

endpackage

// ===== design/gb5_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gb5_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/gb5_ctrl.sv =====
// Configuration registers and raster position counters.
module gb5_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  input  logic [gb5_pkg::IDX_W-1:0] cfg_index,
  input  logic [gb5_pkg::CFG_W-1:0] cfg_data,
  input  logic                      accept,
  input  logic                      frame_start,
  output gb5_pkg::pos_t             pos
);

  logic [gb5_pkg::CFG_W-1:0] width_r, height_r;
  logic [gb5_pkg::CFG_W-1:0] w_eff, h_eff;
  logic [gb5_pkg::POS_W-1:0] col_cnt_r, row_cnt_r;
  logic [gb5_pkg::POS_W-1:0] col_cnt_nxt, row_cnt_nxt;
  logic [gb5_pkg::POS_W-1:0] c_base, r_base, c, r;
  logic [gb5_pkg::CFG_W-1:0] c_inc, r_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= gb5_pkg::WIDTH_RESET;
      height_r <= gb5_pkg::HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gb5_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_data;
        gb5_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r < gb5_pkg::DIM_MIN)        w_eff = gb5_pkg::DIM_MIN;
    else if (width_r > gb5_pkg::WIDTH_MAX) w_eff = gb5_pkg::WIDTH_MAX;
    else                                   w_eff = width_r;
    if (height_r < gb5_pkg::DIM_MIN)         h_eff = gb5_pkg::DIM_MIN;
    else if (height_r > gb5_pkg::HEIGHT_MAX) h_eff = gb5_pkg::HEIGHT_MAX;
    else                                     h_eff = height_r;
  end

  always_comb begin
    c_base = frame_start ? '0 : col_cnt_r;
    r_base = frame_start ? '0 : row_cnt_r;
    // A position left beyond a shrunken frame restarts at zero.
    c = ({1'b0, c_base} >= w_eff) ? '0 : c_base;
    r = ({1'b0, r_base} >= h_eff) ? '0 : r_base;

    pos.col     = c;
    pos.ctr_col = c - gb5_pkg::POS_W'(2);
    pos.ctr_row = r - gb5_pkg::POS_W'(2);
    pos.emit    = (c >= gb5_pkg::POS_W'(4)) && (r >= gb5_pkg::POS_W'(4));
    pos.last    = ({1'b0, r} == h_eff - gb5_pkg::CFG_W'(1)) &&
                  ({1'b0, c} == w_eff - gb5_pkg::CFG_W'(1));

    c_inc = {1'b0, c} + gb5_pkg::CFG_W'(1);
    r_inc = {1'b0, r} + gb5_pkg::CFG_W'(1);
    if (c_inc >= w_eff) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (r_inc >= h_eff) ? '0 : r_inc[gb5_pkg::POS_W-1:0];
    end else begin
      col_cnt_nxt = c_inc[gb5_pkg::POS_W-1:0];
      row_cnt_nxt = r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (accept) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

endmodule

// ===== design/gb5_sum.sv =====
// Separable binomial filter: column sums held in a 5-deep shift line.
module gb5_sum (
  input  logic                      clk,
  input  logic                      shift_en,
  input  gb5_pkg::col_t             col_in,
  output logic [gb5_pkg::PIX_W-1:0] blurred
);

  logic [gb5_pkg::TAPS-1:0][gb5_pkg::VSUM_W-1:0] vsum_r;
  logic [gb5_pkg::VSUM_W-1:0] vsum_new;
  logic [gb5_pkg::HSUM_W-1:0] hsum;
  logic [gb5_pkg::VSUM_W-1:0] p0, p1, p2, p3, p4;
  logic [gb5_pkg::HSUM_W-1:0] v0, v1, v2, v3, v4;

  // Weights 1,4,6,4,1 built from shifts; 6x is 4x plus 2x.
  always_comb begin
    p0 = gb5_pkg::VSUM_W'(col_in[0]);
    p1 = gb5_pkg::VSUM_W'(col_in[1]);
    p2 = gb5_pkg::VSUM_W'(col_in[2]);
    p3 = gb5_pkg::VSUM_W'(col_in[3]);
    p4 = gb5_pkg::VSUM_W'(col_in[4]);
    vsum_new = p0 + (p1 << 2) + (p2 << 2) + (p2 << 1) + (p3 << 2) + p4;
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int j = 0; j < gb5_pkg::TAPS - 1; j++) begin
        vsum_r[j] <= vsum_r[j+1];
      end
      vsum_r[gb5_pkg::TAPS-1] <= vsum_new;
    end
  end

  always_comb begin
    v0 = gb5_pkg::HSUM_W'(vsum_r[0]);
    v1 = gb5_pkg::HSUM_W'(vsum_r[1]);
    v2 = gb5_pkg::HSUM_W'(vsum_r[2]);
    v3 = gb5_pkg::HSUM_W'(vsum_r[3]);
    v4 = gb5_pkg::HSUM_W'(vsum_r[4]);
    hsum = v0 + (v1 << 2) + (v2 << 2) + (v2 << 1) + (v3 << 2) + v4;
    blurred = hsum[gb5_pkg::HSUM_W-1:8];
  end

endmodule

// ===== design/gaussian_blur_5x5.sv =====
// Top level of the 5x5 binomial blur over a raster pixel stream.
//
// Pixels enter on the in_ stream one per clock unless stalled, frame_start
// on in_tuser placing a pixel at row 0, column 0. Four line stores in one
// 64-bit wide RAM supply the rows above; the column read at accept is
// written back shifted by one row in the next stage. For each centre pixel
// at least two pixels from every edge one item leaves on the out_ stream,
// carrying the weighted sum shifted right by 8 and the centre position;
// out_tlast marks the last interior result of the frame. Border pixels
// produce no item. Results pass stage 1, stage 2 and the output register;
// one pixel is taken every cycle while the output is not stalled. The rate
// is set by the single RAM read and write port, each used once per pixel.
// When out_tready is low the result waits in the output register while the
// two empty stages ahead of it still fill; in_tready then drops.
// Image size is written on the cfg_ port (index 0 width, 1 height) while
// the stream is idle; cfg_ready is always high. Synchronous reset clears
// the pipeline, the position counters and restores the default size.
module gaussian_blur_5x5 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] pixel_value
  input  logic        in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] blurred_value, [28:16] center_column,
                                  // [41:29] center_row, [47:42] zero
  output logic        out_tlast,  // frame_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  localparam int LW = gb5_pkg::LINES * gb5_pkg::PIX_W;

  logic          in_acc;
  gb5_pkg::pos_t pos;

  logic                       s1_v_r, s2_v_r, out_v_r;
  logic [gb5_pkg::PIX_W-1:0]  s1_pix_r;
  gb5_pkg::pos_t              s1_pos_r, s2_pos_r;
  logic                       s1_fwd_r;
  logic [LW-1:0]              s1_fwd_data_r;
  logic                       s1_go, s1_rdy, s2_go, s2_rdy;
  logic [LW-1:0]              ram_rd, lines;
  gb5_pkg::col_t              col;
  logic [gb5_pkg::PIX_W-1:0]  blurred;
  logic [gb5_pkg::PIX_W-1:0]  out_blur_r;
  logic [gb5_pkg::POS_W-1:0]  out_col_r, out_row_r;
  logic                       out_last_r;

  assign cfg_ready = 1'b1;

  // Stage handshake: a stage moves when the one after it has room.
  assign s2_go     = s2_v_r && (!s2_pos_r.emit || !out_v_r || out_tready);
  assign s2_rdy    = !s2_v_r || s2_go;
  assign s1_go     = s1_v_r && s2_rdy;
  assign s1_rdy    = !s1_v_r || s1_go;
  assign in_tready = s1_rdy;
  assign in_acc    = in_tvalid && in_tready;

  gb5_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (in_acc),
    .frame_start (in_tuser),
    .pos         (pos)
  );

  gb5_ram #(
    .WIDTH (LW),
    .DEPTH (gb5_pkg::MAX_WIDTH)
  ) u_lines (
    .clk     (clk),
    .wr_en   (s1_go),
    .wr_addr (s1_pos_r.col),
    .wr_data (col[gb5_pkg::TAPS-1:1]),
    .rd_en   (in_acc),
    .rd_addr (pos.col),
    .rd_data (ram_rd)
  );

  // Back-to-back pixels at one column (a frame start after column 0): take the
  // data being written back in that cycle instead of the stale RAM word.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r      <= in_tdata;
      s1_pos_r      <= pos;
      s1_fwd_r      <= s1_go && (s1_pos_r.col == pos.col);
      s1_fwd_data_r <= col[gb5_pkg::TAPS-1:1];
    end
  end

  assign lines = s1_fwd_r ? s1_fwd_data_r : ram_rd;
  assign col   = {s1_pix_r, lines};

  gb5_sum u_sum (
    .clk      (clk),
    .shift_en (s1_go),
    .col_in   (col),
    .blurred  (blurred)
  );

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_pos_r <= s1_pos_r;
    end
    if (s2_go && s2_pos_r.emit) begin
      out_blur_r <= blurred;
      out_col_r  <= s2_pos_r.ctr_col;
      out_row_r  <= s2_pos_r.ctr_row;
      out_last_r <= s2_pos_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_acc;
      if (s2_rdy) s2_v_r <= s1_go;
      if (s2_go && s2_pos_r.emit) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'b0, out_row_r, out_col_r, out_blur_r};
  assign out_tlast  = out_last_r;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the 5x5 binomial blur: a directed frame, random frames, widest sizes.
module tb_top;
  import gb5_pkg::*;

  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RAND_ITEMS   = 400;
  localparam int EDGE_ITEMS   = 40;

  typedef struct packed {
    logic             fend;
    logic [POS_W-1:0] crow;
    logic [POS_W-1:0] ccol;
    logic [PIX_W-1:0] blur;
  } blur_res_t;

  typedef struct {
    logic [PIX_W-1:0] pix;
    logic             sof;
    int               rpt;
    bit               typed;
    blur_res_t        res;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [13:0] cfg_data;

  // Predictor state: line stores, window, position and image size.
  logic [PIX_W-1:0] line_buf [LINES*MAX_WIDTH];
  logic [PIX_W-1:0] win [TAPS][TAPS];
  int unsigned      pos_col;
  int unsigned      pos_row;
  logic [CFG_W-1:0] cfg_width;
  logic [CFG_W-1:0] cfg_height;
  int unsigned      binom [TAPS] = '{1, 4, 6, 4, 1};

  blur_res_t   blur_exp_q [$];
  int          mismatch_cnt = 0;
  int          cycle_cnt = 0;
  int unsigned rdy_hold = 0;
  bit          in_burst = 1'b0;
  bit          out_burst = 1'b0;

  // The whole frame at full scale gives the largest value in the centre.
  dir_row_t dir_tab [2] = '{
    '{pix: 16'hFFFF, sof: 1'b0, rpt: 24, typed: 1'b0, res: '0},
    '{pix: 16'hFFFF, sof: 1'b0, rpt: 1, typed: 1'b1,
      res: '{fend: 1'b1, crow: 13'd2, ccol: 13'd2, blur: 16'hFFFF}}
  };

  gaussian_blur_5x5 i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [15:0] pixel_value
    .in_tuser   (in_tuser),   // [0] frame_start
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [15:0] blurred_value, [28:16] center_column,
                              // [41:29] center_row, [47:42] zero
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned dim_clamp(input logic [CFG_W-1:0] v,
                                            input logic [CFG_W-1:0] hi);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim(input int hi);
    if ($urandom_range(0, 7) == 0) return CFG_W'($urandom_range(0, 4));
    return CFG_W'($urandom_range(5, hi));
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // Steps the blur predictor by one pixel; hit tells whether a result follows.
  task automatic blur_predict(input logic [PIX_W-1:0] pix, input logic sof,
                              output bit hit, output blur_res_t res);
    int unsigned      w;
    int unsigned      h;
    int unsigned      c;
    int unsigned      r;
    int unsigned      sum;
    logic [PIX_W-1:0] vcol [TAPS];
    w = dim_clamp(cfg_width, WIDTH_MAX);
    h = dim_clamp(cfg_height, HEIGHT_MAX);
    if (sof) begin
      pos_col = 0;
      pos_row = 0;
    end
    c = (pos_col >= w) ? 0 : pos_col;
    r = (pos_row >= h) ? 0 : pos_row;
    for (int k = 0; k < LINES; k++) vcol[k] = line_buf[k*MAX_WIDTH + c];
    vcol[LINES] = pix;
    for (int k = 0; k < LINES; k++) line_buf[k*MAX_WIDTH + c] = vcol[k+1];
    for (int i = 0; i < TAPS; i++) begin
      for (int j = 0; j < TAPS - 1; j++) win[i][j] = win[i][j+1];
      win[i][TAPS-1] = vcol[i];
    end
    res = '0;
    hit = (r >= LINES) && (c >= LINES);
    if (hit) begin
      sum = 0;
      for (int i = 0; i < TAPS; i++)
        for (int j = 0; j < TAPS; j++)
          sum += binom[i] * binom[j] * win[i][j];
      res.blur = PIX_W'(sum >> 8);
      res.ccol = POS_W'(c - 2);
      res.crow = POS_W'(r - 2);
      res.fend = (r == h - 1) && (c == w - 1);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    pos_col = c;
    pos_row = r;
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic sof,
                            input bit typed, input blur_res_t typed_res);
    int        gap;
    bit        hit;
    blur_res_t res;
    gap = in_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= sof;
    do @(posedge clk); while (!in_tready);
    blur_predict(pix, sof, hit, res);
    if (typed) blur_exp_q.push_back(typed_res);
    else if (hit) blur_exp_q.push_back(res);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_IMAGE_WIDTH) cfg_width = val;
    else if (idx == REG_IMAGE_HEIGHT) cfg_height = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Pixels at the border give no result, so some may still be in flight.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (blur_exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rdy_hold > 0) begin
      out_tready <= 1'b0;
      rdy_hold--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    blur_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (blur_exp_q.size() == 0) begin
        report_mismatch($sformatf("result with none pending, data %h last %b",
                                  out_tdata, out_tlast));
      end else begin
        want = blur_exp_q.pop_front();
        if (out_tdata[15:0] !== want.blur)
          report_mismatch($sformatf("blurred_value %h, want %h at row %0d col %0d",
                                    out_tdata[15:0], want.blur, want.crow, want.ccol));
        if (out_tdata[28:16] !== want.ccol)
          report_mismatch($sformatf("center_column %0d, want %0d",
                                    out_tdata[28:16], want.ccol));
        if (out_tdata[41:29] !== want.crow)
          report_mismatch($sformatf("center_row %0d, want %0d",
                                    out_tdata[41:29], want.crow));
        if (out_tlast !== want.fend)
          report_mismatch($sformatf("frame_end %b, want %b at row %0d col %0d",
                                    out_tlast, want.fend, want.crow, want.ccol));
      end
      rdy_hold = out_burst ? 0 : $urandom_range(0, 5);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    int          rand_items;
    int unsigned frame_px;
    int unsigned n_px;
    int          n_frames;
    bit          first_phase;
    logic        sof;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    cfg_width  = WIDTH_RESET;
    cfg_height = HEIGHT_RESET;
    pos_col    = 0;
    pos_row    = 0;
    rand_items = 0;
    first_phase = 1'b1;
    foreach (line_buf[k]) line_buf[k] = '0;
    foreach (win[i, j]) win[i][j] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Sizes below the minimum are used as 5; the first pixel after reset
    // sits at row 0, column 0 without a frame start.
    cfg_write(REG_IMAGE_WIDTH, CFG_W'(4));
    cfg_write(REG_IMAGE_HEIGHT, CFG_W'(0));
    foreach (dir_tab[t])
      repeat (dir_tab[t].rpt)
        send_pixel(dir_tab[t].pix, dir_tab[t].sof, dir_tab[t].typed, dir_tab[t].res);

    // Small random frames: whole ones, cut short, run past the end, restarted.
    while (rand_items < RAND_ITEMS) begin
      wait_idle();
      if (first_phase || $urandom_range(0, 3) != 0)
        cfg_write(REG_IMAGE_WIDTH, pick_dim(12));
      if (first_phase || $urandom_range(0, 3) != 0)
        cfg_write(REG_IMAGE_HEIGHT, pick_dim(10));
      if ($urandom_range(0, 5) == 0)
        cfg_write(IDX_W'($urandom_range(int'(REG_IMAGE_HEIGHT) + 1, 255)), CFG_W'($urandom));
      first_phase = 1'b0;
      frame_px = dim_clamp(cfg_width, WIDTH_MAX) * dim_clamp(cfg_height, HEIGHT_MAX);
      n_frames = $urandom_range(1, 3);
      for (int f = 0; f < n_frames; f++) begin
        in_burst  = ($urandom_range(0, 3) == 0);
        out_burst = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 9))
          0: n_px = $urandom_range(1, frame_px - 1);
          1: n_px = frame_px + $urandom_range(1, frame_px);
          default: n_px = frame_px;
        endcase
        for (int unsigned p = 0; p < n_px; p++) begin
          // A frame after a size change must open with a frame start.
          if (p == 0) sof = (f == 0) || ($urandom_range(0, 1) == 1);
          else sof = ($urandom_range(0, 63) == 0);
          send_pixel(rand_pixel(), sof, 1'b0, '0);
          rand_items++;
        end
      end
    end

    // The widest line, then the tallest frame, each only started;
    // all-ones saturates to the maximum.
    for (int s = 0; s < 2; s++) begin
      wait_idle();
      cfg_write(REG_IMAGE_WIDTH, (s == 0) ? {CFG_W{1'b1}} : DIM_MIN);
      cfg_write(REG_IMAGE_HEIGHT, (s == 0) ? DIM_MIN : {CFG_W{1'b1}});
      for (int unsigned p = 0; p < EDGE_ITEMS; p++) begin
        if (p % 1024 == 0) begin
          in_burst  = ($urandom_range(0, 2) != 0);
          out_burst = ($urandom_range(0, 2) != 0);
        end
        send_pixel(rand_pixel(), p == 0, 1'b0, '0);
      end
    end

    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
